// ===== src/largest_empty_square_scan_unit_macros.svh =====
// Assertion macros shared by the largest empty square scan unit.
// Each macro samples on clk and is disabled while rst is high.
`ifndef LARGEST_EMPTY_SQUARE_SCAN_UNIT_MACROS_SVH
`define LARGEST_EMPTY_SQUARE_SCAN_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LESSQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lessq same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LESSQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lessq next-cycle check failed");

`endif

// ===== src/lessq_pkg.sv =====
// Shared constants and types of the largest empty square scan unit.
// No dependencies.
`timescale 1ns / 1ps

package lessq_pkg;

  // Width of the row width register as seen on the configuration port.
  localparam int CFG_W = 11;
  // Row width after reset, before clamping to the line buffer size.
  localparam int ROW_WIDTH_RESET = 1024;

  // Per-cell flags passed from the scan counters to the cell stage.
  typedef struct packed {
    logic obstacle;
    logic grid_start;
    logic first_row;
    logic first_col;
  } cell_flags_t;

endpackage

// ===== src/largest_empty_square_scan_unit.sv =====
// Top level of the largest empty square scan unit.
// Depends on lessq_pkg, lessq_scan_ctrl, lessq_cell_stage and lessq_line_mem.
//
//   Channel  Handshake              Payload
//   in       in_valid / in_ready    obstacle, grid_start
//   out      out_valid / out_ready  cell_square, best_size, best_row, best_col
//   cfg      cfg_valid / cfg_ready  row_width
//
// One cell per cycle unless stalled; results pass the cell stage and output registers.
// The line buffer is read when a request is accepted and written when its result
// is registered; a one-cell row is served by forwarding the written value.
// Reset clears counters, best and handshake state; the line buffer is not cleared.
// A stalled output holds the cell stage; once that stage is full, the input is held
// in the same cycle.
`timescale 1ns / 1ps

module largest_empty_square_scan_unit
  import lessq_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             obstacle,
  input  logic                             grid_start,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [$clog2(MAX_WIDTH + 1)-1:0] cell_square,
  output logic [$clog2(MAX_WIDTH + 1)-1:0] best_size,
  output logic [$clog2(MAX_HEIGHT)-1:0]    best_row,
  output logic [$clog2(MAX_WIDTH)-1:0]     best_col,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [CFG_W-1:0]                 row_width
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int SIZE_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);

  logic              s1_free;
  logic              issue;
  logic [COL_W-1:0]  issue_col;
  logic [ROW_W-1:0]  issue_row;
  cell_flags_t       issue_flags;
  logic [SIZE_W-1:0] rd_data;
  logic              wr_en;
  logic [COL_W-1:0]  wr_addr;
  logic [SIZE_W-1:0] wr_data;

  lessq_scan_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .obstacle    (obstacle),
    .grid_start  (grid_start),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .row_width   (row_width),
    .s1_free     (s1_free),
    .issue       (issue),
    .issue_col   (issue_col),
    .issue_row   (issue_row),
    .issue_flags (issue_flags)
  );

  lessq_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (SIZE_W)
  ) u_line (
    .clk     (clk),
    .rd_en   (issue),
    .rd_addr (issue_col),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  lessq_cell_stage #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cell (
    .clk         (clk),
    .rst         (rst),
    .issue       (issue),
    .issue_col   (issue_col),
    .issue_row   (issue_row),
    .issue_flags (issue_flags),
    .s1_free     (s1_free),
    .rd_data     (rd_data),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cell_square (cell_square),
    .best_size   (best_size),
    .best_row    (best_row),
    .best_col    (best_col)
  );

endmodule

// ===== src/lessq_line_mem.sv =====
// Line buffer holding the square sizes of the previous grid row.
// One write port and one registered read port; no package dependency.
`timescale 1ns / 1ps

module lessq_line_mem #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 11
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Read returns the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

// ===== src/lessq_scan_ctrl.sv =====
// Raster position counters, row width register and input handshake.
// Depends on lessq_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "largest_empty_square_scan_unit_macros.svh"

module lessq_scan_ctrl
  import lessq_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             obstacle,
  input  logic                             grid_start,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [CFG_W-1:0]                 row_width,
  input  logic                             s1_free,
  output logic                             issue,
  output logic [$clog2(MAX_WIDTH)-1:0]     issue_col,
  output logic [$clog2(MAX_HEIGHT)-1:0]    issue_row,
  output cell_flags_t                      issue_flags
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int SIZE_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam logic [SIZE_W-1:0] WIDTH_RESET =
    SIZE_W'((ROW_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : ROW_WIDTH_RESET);

  logic [SIZE_W-1:0] width;
  logic [COL_W-1:0]  column;
  logic [ROW_W-1:0]  row;

  logic [31:0]       cfg_wide;
  logic [SIZE_W-1:0] width_next;
  logic [COL_W-1:0]  col_base;
  logic [COL_W-1:0]  col_eff;
  logic [ROW_W-1:0]  row_eff;
  logic              last_col;
  logic [COL_W-1:0]  column_next;
  logic [ROW_W-1:0]  row_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = s1_free;
  assign issue     = in_valid && in_ready;

  // Out-of-range widths are clamped once, when the register is written.
  always_comb begin
    cfg_wide = 32'(row_width);
    if (cfg_wide == 32'd0) begin
      width_next = SIZE_W'(1);
    end else if (cfg_wide > 32'(MAX_WIDTH)) begin
      width_next = SIZE_W'(MAX_WIDTH);
    end else begin
      width_next = SIZE_W'(cfg_wide);
    end
  end

  always_comb begin
    col_base = grid_start ? '0 : column;
    row_eff  = grid_start ? '0 : row;
    // A narrowed width can leave the column past the row end.
    col_eff  = (SIZE_W'(col_base) >= width) ? '0 : col_base;
    last_col = (SIZE_W'(col_eff) + SIZE_W'(1)) >= width;
    if (last_col) begin
      column_next = '0;
      row_next    = (row_eff == ROW_W'(MAX_HEIGHT - 1)) ? '0 : row_eff + ROW_W'(1);
    end else begin
      column_next = col_eff + COL_W'(1);
      row_next    = row_eff;
    end
  end

  assign issue_col              = col_eff;
  assign issue_row              = row_eff;
  assign issue_flags.obstacle   = obstacle;
  assign issue_flags.grid_start = grid_start;
  assign issue_flags.first_row  = (row_eff == '0);
  assign issue_flags.first_col  = (col_eff == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= WIDTH_RESET;
      column <= '0;
      row    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        width <= width_next;
      end
      if (issue) begin
        column <= column_next;
        row    <= row_next;
      end
    end
  end

  `LESSQ_ASSERT_NEXT(a_start_restarts_scan, issue && grid_start,
    (row == '0 && column == COL_W'(1)) || (row == ROW_W'(1) && column == '0))

endmodule

// ===== src/lessq_cell_stage.sv =====
// Cell stage: square size from the line buffer, best tracking and output register.
// Depends on lessq_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "largest_empty_square_scan_unit_macros.svh"

module lessq_cell_stage
  import lessq_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               issue,
  input  logic [$clog2(MAX_WIDTH)-1:0]       issue_col,
  input  logic [$clog2(MAX_HEIGHT)-1:0]      issue_row,
  input  cell_flags_t                        issue_flags,
  output logic                               s1_free,
  input  logic [$clog2(MAX_WIDTH + 1)-1:0]   rd_data,
  output logic                               wr_en,
  output logic [$clog2(MAX_WIDTH)-1:0]       wr_addr,
  output logic [$clog2(MAX_WIDTH + 1)-1:0]   wr_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [$clog2(MAX_WIDTH + 1)-1:0]   cell_square,
  output logic [$clog2(MAX_WIDTH + 1)-1:0]   best_size,
  output logic [$clog2(MAX_HEIGHT)-1:0]      best_row,
  output logic [$clog2(MAX_WIDTH)-1:0]       best_col
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int SIZE_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);

  logic              s1_valid;
  logic [COL_W-1:0]  s1_col;
  logic [ROW_W-1:0]  s1_row;
  cell_flags_t       s1_flags;
  logic              fwd_hit;
  logic [SIZE_W-1:0] fwd_data;
  logic [SIZE_W-1:0] left_value;
  logic [SIZE_W-1:0] diag_value;
  logic [SIZE_W-1:0] best_q;
  logic [ROW_W-1:0]  best_row_q;
  logic [COL_W-1:0]  best_col_q;

  logic              advance;
  logic              retire;
  logic [SIZE_W-1:0] up;
  logic [SIZE_W-1:0] min_lu;
  logic [SIZE_W-1:0] min3;
  logic [SIZE_W-1:0] val;
  logic [SIZE_W-1:0] best_base;
  logic [ROW_W-1:0]  best_row_base;
  logic [COL_W-1:0]  best_col_base;
  logic              take;

  assign advance = !out_valid || out_ready;
  assign s1_free = !s1_valid || advance;
  assign retire  = s1_valid && advance;

  // With a one-cell row, the entry read for the new cell is the one being written.
  assign up = fwd_hit ? fwd_data : rd_data;

  always_comb begin
    min_lu = (up < left_value) ? up : left_value;
    min3   = (min_lu < diag_value) ? min_lu : diag_value;
    if (s1_flags.obstacle) begin
      val = '0;
    end else if (s1_flags.first_row || s1_flags.first_col) begin
      val = SIZE_W'(1);
    end else begin
      val = min3 + SIZE_W'(1);
    end
    best_base     = s1_flags.grid_start ? '0 : best_q;
    best_row_base = s1_flags.grid_start ? '0 : best_row_q;
    best_col_base = s1_flags.grid_start ? '0 : best_col_q;
    take          = val > best_base;
  end

  assign wr_en   = retire;
  assign wr_addr = s1_col;
  assign wr_data = val;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
      best_q     <= '0;
      best_row_q <= '0;
      best_col_q <= '0;
      left_value <= '0;
      diag_value <= '0;
    end else begin
      if (s1_free) begin
        s1_valid <= issue;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
      if (retire) begin
        left_value <= val;
        diag_value <= up;
        if (take) begin
          best_q     <= val;
          best_row_q <= s1_row;
          best_col_q <= s1_col;
        end else begin
          best_q     <= best_base;
          best_row_q <= best_row_base;
          best_col_q <= best_col_base;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_col   <= issue_col;
      s1_row   <= issue_row;
      s1_flags <= issue_flags;
      fwd_hit  <= retire && (s1_col == issue_col);
      fwd_data <= val;
    end
    if (retire) begin
      cell_square <= val;
      best_size   <= take ? val : best_base;
      best_row    <= take ? s1_row : best_row_base;
      best_col    <= take ? s1_col : best_col_base;
    end
  end

  `LESSQ_ASSERT_NOW(a_cell_within_best, out_valid, cell_square <= best_size)
  `LESSQ_ASSERT_NEXT(a_best_never_drops, retire && !s1_flags.grid_start,
    best_size >= $past(best_q))
  `LESSQ_ASSERT_NEXT(a_stalled_cell_holds, s1_valid && !advance,
    s1_valid && $stable(s1_col) && $stable(s1_row))

endmodule
